FILE: src/gsab_pkg.sv
// Package with shared types and codes of the graph star adjacency builder.
`timescale 1ns / 1ps
package gsab_pkg;

  // Widths of the item fields.
  localparam int NODE_W   = 7;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  // Item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_ARC        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ARCS    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_NODE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_LOADED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_COUNT  = 1'b1;

  // One stored arc.
  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [LEN_W-1:0]  len;
  } arc_t;

endpackage

FILE: src/gsab_in_if.sv
// Input channel interface: valid, ready and one arc or query beat.
`timescale 1ns / 1ps
interface gsab_in_if;
  import gsab_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [NODE_W-1:0] tail_node;
  logic [NODE_W-1:0] head_node;
  logic [LEN_W-1:0]  arc_length;
  logic [NODE_W-1:0] query_node;

  modport source (output valid, mode, tail_node, head_node, arc_length, query_node,
                  input ready);
  modport sink (input valid, mode, tail_node, head_node, arc_length, query_node,
                output ready);
endinterface

FILE: src/gsab_out_if.sv
// Result channel interface: valid, ready and one result beat.
`timescale 1ns / 1ps
interface gsab_out_if;
  import gsab_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] arc_number;
  logic [NODE_W-1:0] arc_tail;
  logic [NODE_W-1:0] arc_head;
  logic [LEN_W-1:0]  arc_weight;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, arc_number, arc_tail, arc_head, arc_weight, status, last,
                  input ready);
  modport sink (input valid, arc_number, arc_tail, arc_head, arc_weight, status, last,
                output ready);
endinterface

FILE: src/gsab_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module gsab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read; rdata holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/graph_star_adjacency_builder.sv
// Top level of the graph star adjacency builder.
`timescale 1ns / 1ps
// Arcs are loaded one beat at a time into an arc RAM, and a second RAM keeps
// arc indexes ordered by head node. A load of the k-th arc makes one
// read-and-compare pass over the stored heads to find the insert place, then
// one read and one write per shifted entry of the head-ordered RAM. A query
// first sweeps all arcs to count the start offsets, marks the outgoing range,
// reads the incoming range from the order RAM, and then walks the arc numbers
// in ascending order, skipping unmarked arcs and emitting one result per
// marked arc; each RAM has a single read port. A query that fails (not
// loaded, bad node, no arcs) gives one result with status set and last
// high. Inputs are taken only when the previous item is finished; a result
// may still wait in the output register while the next input beat is
// taken. After reset no arcs are loaded and no clearing pass is needed.
module graph_star_adjacency_builder #(
  parameter int MAX_ARCS  = 64,
  parameter int MAX_NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gsab_in_if.sink                       in_ch,
  gsab_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [gsab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsab_pkg::CFG_W-1:0]     cfg_wdata
);
  import gsab_pkg::*;

  localparam int AW = $clog2(MAX_ARCS);
  localparam logic [CNT_W-1:0] MAX_ARCS_C  = CNT_W'(MAX_ARCS);
  localparam logic [8:0]       MAX_NODES_C = 9'(MAX_NODES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_LEV  = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SWR  = 4'd4;
  localparam logic [3:0] S_QRD  = 4'd5;
  localparam logic [3:0] S_QEV  = 4'd6;
  localparam logic [3:0] S_QFWD = 4'd7;
  localparam logic [3:0] S_RRD  = 4'd8;
  localparam logic [3:0] S_REV  = 4'd9;
  localparam logic [3:0] S_ESC  = 4'd10;
  localparam logic [3:0] S_EOUT = 4'd11;
  localparam logic [3:0] S_RES  = 4'd12;

  // Control registers.
  logic [3:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    node_count_r, node_count_nxt;
  logic [CFG_W-1:0]    arc_count_r, arc_count_nxt;
  logic [CNT_W-1:0]    loaded_r, loaded_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    cf_lo_r, cf_lo_nxt, cf_hi_r, cf_hi_nxt;
  logic [CNT_W-1:0]    cr_lo_r, cr_lo_nxt, cr_hi_r, cr_hi_nxt;
  logic [MAX_ARCS-1:0] mask_r, mask_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [NODE_W-1:0]   key_r, key_nxt;
  logic [STAT_W-1:0]   res_st_r, res_st_nxt;
  logic [NODE_W-1:0]   o_num_r, o_num_nxt, o_tail_r, o_tail_nxt, o_head_r, o_head_nxt;
  logic [LEN_W-1:0]    o_len_r, o_len_nxt;
  logic [STAT_W-1:0]   o_st_r, o_st_nxt;
  logic                o_last_r, o_last_nxt;

  // RAM ports.
  logic          arc_we, arc_re;
  logic [AW-1:0] arc_waddr, arc_raddr;
  arc_t          arc_wdata, arc_rdata;
  logic          ord_we, ord_re;
  logic [AW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  gsab_ram #(.WIDTH($bits(arc_t)), .DEPTH(MAX_ARCS)) u_arc_ram (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .re(arc_re), .raddr(arc_raddr), .rdata(arc_rdata)
  );

  gsab_ram #(.WIDTH(AW), .DEPTH(MAX_ARCS)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .re(ord_re), .raddr(ord_raddr), .rdata(ord_rdata)
  );

  logic [CNT_W-1:0]    na;
  logic                out_free;
  logic                bad_node;
  logic [MAX_ARCS-1:0] mask_rest;

  assign na       = (arc_count_r < MAX_ARCS_C) ? arc_count_r : MAX_ARCS_C;
  assign out_free = !out_valid_r || out_ch.ready;
  assign bad_node = (in_ch.query_node == '0) ||
                    ({2'b00, in_ch.query_node} > {2'b00, node_count_r}) ||
                    ({2'b00, in_ch.query_node} > MAX_NODES_C);
  assign mask_rest = mask_r & ~(MAX_ARCS'(1) << i_r[AW-1:0]);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.arc_number = o_num_r;
  assign out_ch.arc_tail   = o_tail_r;
  assign out_ch.arc_head   = o_head_r;
  assign out_ch.arc_weight = o_len_r;
  assign out_ch.status     = o_st_r;
  assign out_ch.last       = o_last_r;

  // Sequencer for loads and queries.
  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    arc_count_nxt  = arc_count_r;
    loaded_nxt     = loaded_r;
    i_nxt          = i_r;
    cnt_nxt        = cnt_r;
    cf_lo_nxt      = cf_lo_r;
    cf_hi_nxt      = cf_hi_r;
    cr_lo_nxt      = cr_lo_r;
    cr_hi_nxt      = cr_hi_r;
    mask_nxt       = mask_r;
    key_nxt        = key_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_num_nxt      = o_num_r;
    o_tail_nxt     = o_tail_r;
    o_head_nxt     = o_head_r;
    o_len_nxt      = o_len_r;
    o_st_nxt       = o_st_r;
    o_last_nxt     = o_last_r;
    arc_we         = 1'b0;
    arc_waddr      = loaded_r[AW-1:0];
    arc_wdata      = '{tail: in_ch.tail_node, head: in_ch.head_node, len: in_ch.arc_length};
    arc_re         = 1'b0;
    arc_raddr      = i_r[AW-1:0];
    ord_we         = 1'b0;
    ord_waddr      = i_r[AW-1:0];
    ord_wdata      = ord_rdata;
    ord_re         = 1'b0;
    ord_raddr      = i_r[AW-1:0] - AW'(1);

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count_nxt = cfg_wdata;
        REG_ARC_COUNT:  arc_count_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.mode == MODE_LOAD) begin
            if (loaded_r < na) begin
              arc_we    = 1'b1;
              key_nxt   = in_ch.head_node;
              i_nxt     = '0;
              cnt_nxt   = '0;
              state_nxt = S_LRD;
            end
          end else if (loaded_r < na) begin
            res_st_nxt = ST_NOT_LOADED;
            state_nxt  = S_RES;
          end else if (bad_node) begin
            res_st_nxt = ST_BAD_NODE;
            state_nxt  = S_RES;
          end else begin
            key_nxt   = in_ch.query_node;
            i_nxt     = '0;
            cf_lo_nxt = '0;
            cf_hi_nxt = '0;
            cr_lo_nxt = '0;
            cr_hi_nxt = '0;
            mask_nxt  = '0;
            state_nxt = S_QRD;
          end
        end
      end
      // Count earlier arcs whose head is at most the new head.
      S_LRD: begin
        if (i_r == loaded_r) begin
          state_nxt = S_SRD;
        end else begin
          arc_re    = 1'b1;
          state_nxt = S_LEV;
        end
      end
      S_LEV: begin
        if (arc_rdata.head <= key_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_LRD;
      end
      // Shift the order entries above the insert place up by one.
      S_SRD: begin
        if (i_r == cnt_r) begin
          ord_we     = 1'b1;
          ord_wdata  = loaded_r[AW-1:0];
          loaded_nxt = loaded_r + CNT_W'(1);
          state_nxt  = S_IDLE;
        end else begin
          ord_re    = 1'b1;
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        ord_we    = 1'b1;
        i_nxt     = i_r - CNT_W'(1);
        state_nxt = S_SRD;
      end
      // Count tails and heads below and up to the queried node.
      S_QRD: begin
        if (i_r == na) begin
          state_nxt = S_QFWD;
        end else begin
          arc_re    = 1'b1;
          state_nxt = S_QEV;
        end
      end
      S_QEV: begin
        if (arc_rdata.tail < key_r)  cf_lo_nxt = cf_lo_r + CNT_W'(1);
        if (arc_rdata.tail <= key_r) cf_hi_nxt = cf_hi_r + CNT_W'(1);
        if (arc_rdata.head < key_r)  cr_lo_nxt = cr_lo_r + CNT_W'(1);
        if (arc_rdata.head <= key_r) cr_hi_nxt = cr_hi_r + CNT_W'(1);
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_QRD;
      end
      // Mark the outgoing arcs, which sit in load order.
      S_QFWD: begin
        for (int m = 0; m < MAX_ARCS; m++) begin
          if ((CNT_W'(m) >= cf_lo_r) && (CNT_W'(m) < cf_hi_r)) begin
            mask_nxt[m] = 1'b1;
          end
        end
        i_nxt     = cr_lo_r;
        state_nxt = S_RRD;
      end
      // Mark the incoming arcs through the head order.
      S_RRD: begin
        if (i_r == cr_hi_r) begin
          i_nxt = '0;
          if (mask_r == '0) begin
            res_st_nxt = ST_NO_ARCS;
            state_nxt  = S_RES;
          end else begin
            state_nxt = S_ESC;
          end
        end else begin
          ord_re    = 1'b1;
          ord_raddr = i_r[AW-1:0];
          state_nxt = S_REV;
        end
      end
      S_REV: begin
        mask_nxt[ord_rdata] = 1'b1;
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_RRD;
      end
      // Walk the marked arcs in ascending number.
      S_ESC: begin
        if (mask_r[i_r[AW-1:0]]) begin
          arc_re    = 1'b1;
          state_nxt = S_EOUT;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_num_nxt     = NODE_W'(i_r) + NODE_W'(1);
          o_tail_nxt    = arc_rdata.tail;
          o_head_nxt    = arc_rdata.head;
          o_len_nxt     = arc_rdata.len;
          o_st_nxt      = ST_ARC;
          o_last_nxt    = (mask_rest == '0);
          mask_nxt      = mask_rest;
          i_nxt         = i_r + CNT_W'(1);
          state_nxt     = (mask_rest == '0) ? S_IDLE : S_ESC;
        end
      end
      // Single status result.
      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_num_nxt     = '0;
          o_tail_nxt    = '0;
          o_head_nxt    = '0;
          o_len_nxt     = '0;
          o_st_nxt      = res_st_r;
          o_last_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CFG_W'(64);
      arc_count_r  <= CFG_W'(64);
      loaded_r     <= '0;
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      cnt_r        <= '0;
      cf_lo_r      <= '0;
      cf_hi_r      <= '0;
      cr_lo_r      <= '0;
      cr_hi_r      <= '0;
      mask_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      arc_count_r  <= arc_count_nxt;
      loaded_r     <= loaded_nxt;
      out_valid_r  <= out_valid_nxt;
      i_r          <= i_nxt;
      cnt_r        <= cnt_nxt;
      cf_lo_r      <= cf_lo_nxt;
      cf_hi_r      <= cf_hi_nxt;
      cr_lo_r      <= cr_lo_nxt;
      cr_hi_r      <= cr_hi_nxt;
      mask_r       <= mask_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    res_st_r <= res_st_nxt;
    o_num_r  <= o_num_nxt;
    o_tail_r <= o_tail_nxt;
    o_head_r <= o_head_nxt;
    o_len_r  <= o_len_nxt;
    o_st_r   <= o_st_nxt;
    o_last_r <= o_last_nxt;
  end

endmodule
